FILE: sv/mdes_pkg.sv
// Shared types, constants and helpers of the motor driver enable sequencer.
// Used by the core, its port checker and the bench; depends on nothing else.
`default_nettype none

package mdes_pkg;

  localparam int TIME_BITS_DEFAULT = 32;

  // Configuration register indexes.
  localparam logic [2:0] CFG_PWM_ZERO_LIMIT = 3'd0;
  localparam logic [2:0] CFG_ZERO_HOLD      = 3'd1;
  localparam logic [2:0] CFG_COND_HOLD      = 3'd2;
  localparam logic [2:0] CFG_ARM            = 3'd3;
  localparam logic [2:0] CFG_SETTLE         = 3'd4;
  localparam logic [2:0] CFG_GUARD          = 3'd5;

  // Register reset values.
  localparam logic [14:0] PWM_ZERO_LIMIT_RST = 15'd1638;
  localparam logic [15:0] ZERO_HOLD_RST      = 16'd80;
  localparam logic [15:0] COND_HOLD_RST      = 16'd100;
  localparam logic [15:0] ARM_RST            = 16'd100;
  localparam logic [15:0] SETTLE_RST         = 16'd80;
  localparam logic [15:0] GUARD_RST          = 16'd120;

  // Sequencer state codes as they appear on the state output.
  localparam logic [1:0] DRV_DISABLED = 2'd0;
  localparam logic [1:0] DRV_ARMING   = 2'd1;
  localparam logic [1:0] DRV_SETTLING = 2'd2;
  localparam logic [1:0] DRV_ACTIVE   = 2'd3;

  // Status flag bit positions.
  localparam int SF_SYS_ACTIVE = 0;
  localparam int SF_FAULT      = 1;
  localparam int SF_RUN        = 2;
  localparam int SF_REARM      = 3;
  localparam int SF_IBUS       = 4;
  localparam int SF_AUTO_REV   = 5;
  localparam int SF_CMD_ZERO   = 6;

  // True when a Q1.15 value has magnitude strictly below the limit.
  // The most negative value has magnitude 32768 and never qualifies.
  function automatic logic pwm_near_zero(input logic signed [15:0] v,
                                         input logic [14:0] limit);
    logic [16:0] mag;
    mag = v[15] ? (17'd0 - {v[15], v}) : {1'b0, v};
    return mag < {2'b00, limit};
  endfunction

endpackage

`default_nettype wire

FILE: sv/motor_driver_enable_sequencer_core.sv
// Latency: a request's result is registered and shown the cycle after it is accepted.
// Throughput: one request per cycle; the output register lets a new request in
// whenever the pending result is taken in the same cycle or none is pending.
// The state update is one pass of compares and timestamp subtractions.
// Reset (rst_n low, synchronous): state DISABLED, all timestamps zero,
// configuration registers at their default values, no result pending.
// Depends on mdes_pkg.
`default_nettype none

module motor_driver_enable_sequencer_core
  import mdes_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // configuration writes
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  // update requests
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [31:0]        in_now_ms,
  input  wire logic [6:0]         in_status_flags,
  input  wire logic [1:0]         in_rc_neutral,
  input  wire logic [3:0]         in_direction_bits,
  input  wire logic signed [15:0] in_cur_left,
  input  wire logic signed [15:0] in_cur_right,
  input  wire logic signed [15:0] in_tgt_left,
  input  wire logic signed [15:0] in_tgt_right,
  // results
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_driver_enable,
  output logic                    out_bridge_off,
  output logic                    out_force_zero,
  output logic [1:0]              out_drv_state
);

  typedef logic [TIME_BITS-1:0] tstamp_t;

  typedef enum logic [1:0] {
    ST_DISABLED = DRV_DISABLED,
    ST_ARMING   = DRV_ARMING,
    ST_SETTLING = DRV_SETTLING,
    ST_ACTIVE   = DRV_ACTIVE
  } seq_state_t;

  logic [14:0] pwm_zero_limit_r;
  logic [15:0] zero_hold_r, cond_hold_r, arm_r, settle_r, guard_r;

  seq_state_t  state_r, state_nxt;
  tstamp_t     zero_since_r, zero_since_nxt;
  tstamp_t     cond_since_r, cond_since_nxt;
  tstamp_t     arm_start_r, arm_start_nxt;
  tstamp_t     enabled_at_r, enabled_at_nxt;
  tstamp_t     active_start_r, active_start_nxt;

  logic        out_valid_r;
  logic        drv_en_r, bridge_off_r, force_zero_r;
  logic [1:0]  drv_state_r;
  logic        bridge_off_nxt, force_zero_nxt;

  logic [63:0] now_wide;
  tstamp_t     now;
  logic        cmd_zero, pwm_safe, zero_ok, flags_ok, cond, cond_ok;
  logic        in_fire;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;

  // Only the low TIME_BITS bits of the timestamp take part.
  assign now_wide = {32'd0, in_now_ms};
  assign now      = now_wide[TIME_BITS-1:0];

  assign cmd_zero = in_status_flags[SF_CMD_ZERO];
  assign pwm_safe = pwm_near_zero(in_cur_left, pwm_zero_limit_r)
                 && pwm_near_zero(in_cur_right, pwm_zero_limit_r)
                 && pwm_near_zero(in_tgt_left, pwm_zero_limit_r)
                 && pwm_near_zero(in_tgt_right, pwm_zero_limit_r);
  assign flags_ok = in_status_flags[SF_SYS_ACTIVE] && !in_status_flags[SF_FAULT]
                 && in_status_flags[SF_RUN] && !in_status_flags[SF_REARM]
                 && !in_status_flags[SF_IBUS] && !in_status_flags[SF_AUTO_REV];

  always_comb begin
    zero_since_nxt   = zero_since_r;
    cond_since_nxt   = cond_since_r;
    arm_start_nxt    = arm_start_r;
    enabled_at_nxt   = enabled_at_r;
    active_start_nxt = active_start_r;
    state_nxt        = state_r;
    bridge_off_nxt   = 1'b0;
    force_zero_nxt   = 1'b0;

    // A start stamp of zero means the episode has not started.
    if (cmd_zero) begin
      if (zero_since_r == '0) zero_since_nxt = now;
    end else begin
      zero_since_nxt = '0;
    end
    zero_ok = cmd_zero && (zero_since_nxt != '0)
           && ((now - zero_since_nxt) >= TIME_BITS'(zero_hold_r));

    cond = flags_ok && pwm_safe && (in_rc_neutral == 2'b11) && zero_ok
        && (in_direction_bits == 4'd0);

    if (cond) begin
      if (cond_since_r == '0) cond_since_nxt = now;
    end else begin
      cond_since_nxt = '0;
    end
    cond_ok = (cond_since_nxt != '0)
           && ((now - cond_since_nxt) >= TIME_BITS'(cond_hold_r));

    case (state_r)
      ST_DISABLED: begin
        bridge_off_nxt = 1'b1;
        force_zero_nxt = 1'b1;
        if (cond_ok) begin
          state_nxt     = ST_ARMING;
          arm_start_nxt = now;
        end
      end
      ST_ARMING: begin
        if (!cond) begin
          state_nxt = ST_DISABLED;
        end else if ((now - arm_start_r) >= TIME_BITS'(arm_r)) begin
          bridge_off_nxt = 1'b1;
          force_zero_nxt = 1'b1;
          enabled_at_nxt = now;
          state_nxt      = ST_SETTLING;
        end
      end
      ST_SETTLING: begin
        force_zero_nxt = 1'b1;
        if ((now - enabled_at_r) >= TIME_BITS'(settle_r)) begin
          state_nxt        = ST_ACTIVE;
          active_start_nxt = now;
        end
      end
      ST_ACTIVE: begin
        if ((now - active_start_r) < TIME_BITS'(guard_r)) force_zero_nxt = 1'b1;
        if (!cond) begin
          bridge_off_nxt = 1'b1;
          state_nxt      = ST_DISABLED;
        end
      end
      default: begin
        state_nxt = ST_DISABLED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pwm_zero_limit_r <= PWM_ZERO_LIMIT_RST;
      zero_hold_r      <= ZERO_HOLD_RST;
      cond_hold_r      <= COND_HOLD_RST;
      arm_r            <= ARM_RST;
      settle_r         <= SETTLE_RST;
      guard_r          <= GUARD_RST;
      state_r          <= ST_DISABLED;
      zero_since_r     <= '0;
      cond_since_r     <= '0;
      arm_start_r      <= '0;
      enabled_at_r     <= '0;
      active_start_r   <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_PWM_ZERO_LIMIT: pwm_zero_limit_r <= cfg_data[14:0];
          CFG_ZERO_HOLD:      zero_hold_r      <= cfg_data;
          CFG_COND_HOLD:      cond_hold_r      <= cfg_data;
          CFG_ARM:            arm_r            <= cfg_data;
          CFG_SETTLE:         settle_r         <= cfg_data;
          CFG_GUARD:          guard_r          <= cfg_data;
          default: ;
        endcase
      end
      if (in_fire) begin
        state_r        <= state_nxt;
        zero_since_r   <= zero_since_nxt;
        cond_since_r   <= cond_since_nxt;
        arm_start_r    <= arm_start_nxt;
        enabled_at_r   <= enabled_at_nxt;
        active_start_r <= active_start_nxt;
        out_valid_r    <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    // Result payload needs no reset; it is qualified by out_valid_r.
    if (in_fire) begin
      drv_en_r     <= (state_nxt == ST_SETTLING) || (state_nxt == ST_ACTIVE);
      bridge_off_r <= bridge_off_nxt;
      force_zero_r <= force_zero_nxt;
      drv_state_r  <= state_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_driver_enable = drv_en_r;
  assign out_bridge_off    = bridge_off_r;
  assign out_force_zero    = force_zero_r;
  assign out_drv_state     = drv_state_r;

endmodule

`default_nettype wire

FILE: sv/mdes_port_checker.sv
// Port-level checks for the motor driver enable sequencer core.
// Depends on mdes_pkg; bound to motor_driver_enable_sequencer_core below.
`default_nettype none

module mdes_port_checker
  import mdes_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_driver_enable,
  input wire logic       out_bridge_off,
  input wire logic       out_force_zero,
  input wire logic [1:0] out_drv_state
);

  // A stalled result must hold until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_drv_state)
      && $stable(out_bridge_off) && $stable(out_force_zero))
    else $error("stalled result changed");

  // With no result pending, the core must always be ready for a new request.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("request blocked while output register is empty");

  // The enable pin is high exactly in settling and active.
  a_enable_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_driver_enable ==
      (out_drv_state == DRV_SETTLING || out_drv_state == DRV_ACTIVE))
    else $error("enable pin disagrees with state");

  // A settling result always has the force-zero output set.
  a_settling_forces_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_drv_state == DRV_SETTLING |-> out_force_zero)
    else $error("settling result without forced zero");

endmodule

bind motor_driver_enable_sequencer_core mdes_port_checker u_mdes_port_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_driver_enable (out_driver_enable),
  .out_bridge_off    (out_bridge_off),
  .out_force_zero    (out_force_zero),
  .out_drv_state     (out_drv_state)
);

`default_nettype wire

FILE: sim/enable_scoreboard_pkg.sv
// Request and result types and the scoreboard of the motor driver enable sequencer bench.
// The scoreboard keeps its own copy of the sequencer state and registers.
// Depends on mdes_pkg for register indexes, reset values, state codes and flag bits.

package enable_scoreboard_pkg;

  import mdes_pkg::*;

  typedef struct {
    logic [31:0]        now_ms;
    logic [6:0]         status_flags;
    logic [1:0]         rc_neutral;
    logic [3:0]         direction_bits;
    logic signed [15:0] cur_left;
    logic signed [15:0] cur_right;
    logic signed [15:0] tgt_left;
    logic signed [15:0] tgt_right;
  } drive_update_t;

  typedef struct {
    logic       driver_enable;
    logic       bridge_off;
    logic       force_zero;
    logic [1:0] drv_state;
  } drive_outputs_t;

  class enable_scoreboard;
    logic [14:0]    zero_limit;
    logic [15:0]    zero_hold;
    logic [15:0]    cond_hold;
    logic [15:0]    arm_wait;
    logic [15:0]    settle_wait;
    logic [15:0]    guard_wait;
    logic [31:0]    zero_since;
    logic [31:0]    cond_since;
    logic [31:0]    arm_start;
    logic [31:0]    enabled_at;
    logic [31:0]    active_start;
    logic [1:0]     seq_state;
    drive_outputs_t expected_outputs[$];
    int             errors;

    function new();
      zero_limit   = PWM_ZERO_LIMIT_RST;
      zero_hold    = ZERO_HOLD_RST;
      cond_hold    = COND_HOLD_RST;
      arm_wait     = ARM_RST;
      settle_wait  = SETTLE_RST;
      guard_wait   = GUARD_RST;
      zero_since   = '0;
      cond_since   = '0;
      arm_start    = '0;
      enabled_at   = '0;
      active_start = '0;
      seq_state    = DRV_DISABLED;
      errors       = 0;
    endfunction

    function void write_register(logic [2:0] index, logic [15:0] data);
      case (index)
        CFG_PWM_ZERO_LIMIT: zero_limit  = data[14:0];
        CFG_ZERO_HOLD:      zero_hold   = data;
        CFG_COND_HOLD:      cond_hold   = data;
        CFG_ARM:            arm_wait    = data;
        CFG_SETTLE:         settle_wait = data;
        CFG_GUARD:          guard_wait  = data;
        default: ;
      endcase
    endfunction

    // Timestamp differences wrap at 32 bits.
    function logic [31:0] elapsed(logic [31:0] now, logic [31:0] start);
      return now - start;
    endfunction

    function bit below_limit(logic signed [15:0] v);
      int mag;
      mag = v;
      if (mag < 0) mag = -mag;
      return mag < int'(zero_limit);
    endfunction

    function void note_update(drive_update_t u);
      logic           cmd_zero;
      logic           pwm_safe;
      logic           zero_ok;
      logic           cond;
      logic           cond_ok;
      drive_outputs_t r;
      cmd_zero = u.status_flags[SF_CMD_ZERO];
      pwm_safe = below_limit(u.cur_left) && below_limit(u.cur_right) &&
                 below_limit(u.tgt_left) && below_limit(u.tgt_right);

      // A start stamp of zero means the hold has not started yet.
      if (cmd_zero) begin
        if (zero_since == 0) zero_since = u.now_ms;
      end else begin
        zero_since = '0;
      end
      zero_ok = cmd_zero && (zero_since != 0) &&
                (elapsed(u.now_ms, zero_since) >= {16'd0, zero_hold});

      cond = u.status_flags[SF_SYS_ACTIVE] && !u.status_flags[SF_FAULT] &&
             u.status_flags[SF_RUN] && !u.status_flags[SF_REARM] &&
             !u.status_flags[SF_IBUS] && !u.status_flags[SF_AUTO_REV] &&
             pwm_safe && (u.rc_neutral == 2'b11) && zero_ok && (u.direction_bits == 4'd0);

      if (cond) begin
        if (cond_since == 0) cond_since = u.now_ms;
      end else begin
        cond_since = '0;
      end
      cond_ok = (cond_since != 0) && (elapsed(u.now_ms, cond_since) >= {16'd0, cond_hold});

      r.bridge_off = 1'b0;
      r.force_zero = 1'b0;
      case (seq_state)
        DRV_DISABLED: begin
          r.bridge_off = 1'b1;
          r.force_zero = 1'b1;
          if (cond_ok) begin
            seq_state = DRV_ARMING;
            arm_start = u.now_ms;
          end
        end
        DRV_ARMING: begin
          // Losing the conditions here drops back quietly, with no bridge-off pulse.
          if (!cond) begin
            seq_state = DRV_DISABLED;
          end else if (elapsed(u.now_ms, arm_start) >= {16'd0, arm_wait}) begin
            r.bridge_off = 1'b1;
            r.force_zero = 1'b1;
            enabled_at   = u.now_ms;
            seq_state    = DRV_SETTLING;
          end
        end
        DRV_SETTLING: begin
          r.force_zero = 1'b1;
          if (elapsed(u.now_ms, enabled_at) >= {16'd0, settle_wait}) begin
            seq_state    = DRV_ACTIVE;
            active_start = u.now_ms;
          end
        end
        default: begin
          if (elapsed(u.now_ms, active_start) < {16'd0, guard_wait}) r.force_zero = 1'b1;
          if (!cond) begin
            r.bridge_off = 1'b1;
            seq_state    = DRV_DISABLED;
          end
        end
      endcase
      r.driver_enable = (seq_state == DRV_SETTLING) || (seq_state == DRV_ACTIVE);
      r.drv_state     = seq_state;
      expected_outputs.push_back(r);
    endfunction

    function void compare_field(string name, logic [1:0] exp_v, logic [1:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_output(drive_outputs_t act);
      drive_outputs_t exp_r;
      if (expected_outputs.size() == 0) begin
        $display("%0t: result with no request waiting, expected none, actual state %0d",
                 $time, act.drv_state);
        errors++;
        return;
      end
      exp_r = expected_outputs.pop_front();
      compare_field("driver_enable", exp_r.driver_enable, act.driver_enable);
      compare_field("bridge_off", exp_r.bridge_off, act.bridge_off);
      compare_field("force_zero", exp_r.force_zero, act.force_zero);
      compare_field("drv_state", exp_r.drv_state, act.drv_state);
    endfunction
  endclass

endpackage

FILE: sim/tb_motor_driver_enable_sequencer_core.sv
// Top-level bench of motor_driver_enable_sequencer_core: drives update requests and
// register writes, applies back-pressure, and checks every result against the scoreboard.
// Depends on mdes_pkg, enable_scoreboard_pkg and the core itself.

module tb_motor_driver_enable_sequencer_core;

  timeunit 1ns;
  timeprecision 1ps;

  import mdes_pkg::*;
  import enable_scoreboard_pkg::*;

  localparam int         WATCHDOG_LIMIT   = 2000;
  localparam int         LONG_HOLD_CYCLES = 60;
  localparam int         PHASE_ITEMS      = 100;
  localparam logic [2:0] CFG_SPARE_6      = 3'd6;
  localparam logic [2:0] CFG_SPARE_7      = 3'd7;
  localparam logic [6:0] SAFE_FLAGS       =
    7'((1 << SF_SYS_ACTIVE) | (1 << SF_RUN) | (1 << SF_CMD_ZERO));

  logic               clk;
  logic               rst_n;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [15:0]        cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic [31:0]        in_now_ms;
  logic [6:0]         in_status_flags;
  logic [1:0]         in_rc_neutral;
  logic [3:0]         in_direction_bits;
  logic signed [15:0] in_cur_left;
  logic signed [15:0] in_cur_right;
  logic signed [15:0] in_tgt_left;
  logic signed [15:0] in_tgt_right;
  logic               out_valid;
  logic               out_ready;
  logic               out_driver_enable;
  logic               out_bridge_off;
  logic               out_force_zero;
  logic [1:0]         out_drv_state;

  enable_scoreboard sb;
  int               send_gap_pct      = 0;
  int               recv_stall_pct    = 0;
  bit               long_hold_request = 1'b0;
  int               idle_cycles       = 0;
  int               clean_left        = 0;
  logic [31:0]      stamp             = '0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  motor_driver_enable_sequencer_core u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_now_ms         (in_now_ms),
    .in_status_flags   (in_status_flags),
    .in_rc_neutral     (in_rc_neutral),
    .in_direction_bits (in_direction_bits),
    .in_cur_left       (in_cur_left),
    .in_cur_right      (in_cur_right),
    .in_tgt_left       (in_tgt_left),
    .in_tgt_right      (in_tgt_right),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_driver_enable (out_driver_enable),
    .out_bridge_off    (out_bridge_off),
    .out_force_zero    (out_force_zero),
    .out_drv_state     (out_drv_state)
  );

  // Result side: random stalls, plus one long hold-off on request from the main flow.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_request) begin
        hold_left         = LONG_HOLD_CYCLES;
        long_hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_register(cfg_index, cfg_data);
      if (in_valid && in_ready) begin
        sb.note_update('{now_ms: in_now_ms, status_flags: in_status_flags,
                         rc_neutral: in_rc_neutral, direction_bits: in_direction_bits,
                         cur_left: in_cur_left, cur_right: in_cur_right,
                         tgt_left: in_tgt_left, tgt_right: in_tgt_right});
      end
      if (out_valid && out_ready) begin
        sb.check_output('{driver_enable: out_driver_enable, bridge_off: out_bridge_off,
                          force_zero: out_force_zero, drv_state: out_drv_state});
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[motor_driver_enable_sequencer_core] ERROR");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the request is taken,
  // with in_valid still high so that a following request does not toggle it.
  task automatic send_update(input drive_update_t u);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_now_ms         <= u.now_ms;
    in_status_flags   <= u.status_flags;
    in_rc_neutral     <= u.rc_neutral;
    in_direction_bits <= u.direction_bits;
    in_cur_left       <= u.cur_left;
    in_cur_right      <= u.cur_right;
    in_tgt_left       <= u.tgt_left;
    in_tgt_right      <= u.tgt_right;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_fields(input logic [31:0] now, input logic [6:0] flags,
                             input logic [1:0] rc, input logic [3:0] dir,
                             input logic signed [15:0] cl, input logic signed [15:0] cr,
                             input logic signed [15:0] tl, input logic signed [15:0] tr);
    send_update('{now_ms: now, status_flags: flags, rc_neutral: rc, direction_bits: dir,
                  cur_left: cl, cur_right: cr, tgt_left: tl, tgt_right: tr});
  endtask

  task automatic write_register(input logic [2:0] index, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Registers change only once every outstanding result has been taken.
  task automatic apply_settings(input logic [14:0] limit, input logic [15:0] zero_hold,
                                input logic [15:0] cond_hold, input logic [15:0] arm_wait,
                                input logic [15:0] settle_wait, input logic [15:0] guard_wait);
    in_valid <= 1'b0;
    while (sb.expected_outputs.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
    write_register(CFG_PWM_ZERO_LIMIT, {1'b0, limit});
    write_register(CFG_ZERO_HOLD, zero_hold);
    write_register(CFG_COND_HOLD, cond_hold);
    write_register(CFG_ARM, arm_wait);
    write_register(CFG_SETTLE, settle_wait);
    write_register(CFG_GUARD, guard_wait);
    write_register(CFG_SPARE_6, 16'($urandom));
    write_register(CFG_SPARE_7, 16'($urandom));
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Changes the idling mix on a rising edge so the receiver reads it cleanly.
  task automatic set_idling(input int gap_pct, input int stall_pct, input bit long_hold);
    @(posedge clk);
    send_gap_pct      = gap_pct;
    recv_stall_pct    = stall_pct;
    long_hold_request = long_hold;
    @(negedge clk);
  endtask

  function automatic logic signed [15:0] quiet_pwm();
    int m;
    if (sb.zero_limit == 0) return 16'($urandom);
    m = $urandom_range(int'(sb.zero_limit) - 1);
    return $urandom_range(1) ? 16'(-m) : 16'(m);
  endfunction

  function automatic logic signed [15:0] loud_pwm();
    int m;
    if ($urandom_range(3) == 0) return 16'sh8000;
    m = $urandom_range(32767, int'(sb.zero_limit));
    return $urandom_range(1) ? 16'(-m) : 16'(m);
  endfunction

  // Mostly long runs of safe updates with advancing time, so the sequence can reach
  // ACTIVE; each run ends with one broken condition or a fully random update.
  function automatic drive_update_t make_update(input int step_max);
    drive_update_t u;
    int            roll;
    int            b;
    roll = $urandom_range(99);
    if (roll == 0) stamp = $urandom;
    else if (roll == 1) stamp = 32'hFFFF_FFFF - 32'($urandom_range(step_max));
    else stamp = stamp + 32'($urandom_range(step_max));
    u.now_ms         = stamp;
    u.status_flags   = SAFE_FLAGS;
    u.rc_neutral     = 2'b11;
    u.direction_bits = 4'd0;
    u.cur_left       = quiet_pwm();
    u.cur_right      = quiet_pwm();
    u.tgt_left       = quiet_pwm();
    u.tgt_right      = quiet_pwm();
    if (clean_left > 0) begin
      clean_left--;
    end else begin
      clean_left = $urandom_range(60, 5);
      case ($urandom_range(4))
        0: begin
          b = $urandom_range(6);
          u.status_flags[b] = ~u.status_flags[b];
        end
        1: u.rc_neutral = 2'($urandom_range(2));
        2: u.direction_bits = 4'($urandom_range(15, 1));
        3: begin
          case ($urandom_range(3))
            0: u.cur_left = loud_pwm();
            1: u.cur_right = loud_pwm();
            2: u.tgt_left = loud_pwm();
            default: u.tgt_right = loud_pwm();
          endcase
        end
        default: begin
          u.status_flags   = 7'($urandom);
          u.rc_neutral     = 2'($urandom);
          u.direction_bits = 4'($urandom);
          u.cur_left       = 16'($urandom);
          u.cur_right      = 16'($urandom);
          u.tgt_left       = 16'($urandom);
          u.tgt_right      = 16'($urandom);
        end
      endcase
    end
    return u;
  endfunction

  task automatic run_random(input int count);
    int total;
    total = sb.zero_hold + sb.cond_hold + sb.arm_wait + sb.settle_wait + sb.guard_wait;
    repeat (count) send_update(make_update(total / 8 + 2));
  endtask

  initial begin
    sb                = new();
    rst_n             = 1'b0;
    cfg_valid         = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    in_valid          = 1'b0;
    in_now_ms         = '0;
    in_status_flags   = '0;
    in_rc_neutral     = '0;
    in_direction_bits = '0;
    in_cur_left       = '0;
    in_cur_right      = '0;
    in_tgt_left       = '0;
    in_tgt_right      = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed walk at the reset settings.
    send_fields(32'd0, 7'h7F, 2'd0, 4'hF, 16'sh7FFF, 16'sh8000, 16'sd0, -16'sd1);
    send_fields(32'hFFFF_FFFF, 7'h00, 2'd3, 4'h0, 16'sh8000, 16'sh7FFF, 16'sd1, 16'sd0);
    // A hold that starts at time zero counts as not started.
    send_fields(32'd0, SAFE_FLAGS, 2'd3, 4'h0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_fields(32'd10, SAFE_FLAGS, 2'd3, 4'h0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_fields(32'd89, SAFE_FLAGS, 2'd3, 4'h0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_fields(32'd90, SAFE_FLAGS, 2'd3, 4'h0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_fields(32'd190, SAFE_FLAGS, 2'd3, 4'h0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_fields(32'd250, SAFE_FLAGS, 2'd3, 4'h0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_fields(32'd290, SAFE_FLAGS, 2'd3, 4'h0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    // Conditions are not looked at while settling.
    send_fields(32'd300, 7'h02, 2'd0, 4'hF, 16'sh8000, 16'sd0, 16'sd0, 16'sd0);
    send_fields(32'd370, SAFE_FLAGS, 2'd3, 4'h0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_fields(32'd400, SAFE_FLAGS, 2'd3, 4'h0, 16'sd5, -16'sd5, 16'sd0, 16'sd0);
    send_fields(32'd490, SAFE_FLAGS, 2'd3, 4'h0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    // The most negative PWM value is never near zero, so the condition hold restarts.
    send_fields(32'd495, SAFE_FLAGS, 2'd3, 4'h0, 16'sh8000, 16'sd0, 16'sd0, 16'sd0);
    send_fields(32'd500, SAFE_FLAGS, 2'd3, 4'h0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_fields(32'd580, SAFE_FLAGS, 2'd3, 4'h0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_fields(32'd680, SAFE_FLAGS, 2'd3, 4'h0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    // Losing the conditions while arming.
    send_fields(32'd700, SAFE_FLAGS, 2'd1, 4'h0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_fields(32'd710, SAFE_FLAGS, 2'd3, 4'h0, 16'sd1637, -16'sd1637, 16'sd0, 16'sd0);
    send_fields(32'd711, SAFE_FLAGS, 2'd3, 4'h0, 16'sd1638, 16'sd0, 16'sd0, 16'sd0);

    apply_settings(PWM_ZERO_LIMIT_RST, ZERO_HOLD_RST, COND_HOLD_RST, ARM_RST, SETTLE_RST,
                   GUARD_RST);
    run_random(PHASE_ITEMS);

    apply_settings(15'h7FFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    set_idling(69, 0, 1'b0);
    run_random(PHASE_ITEMS);

    apply_settings(15'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    set_idling(0, 69, 1'b0);
    run_random(PHASE_ITEMS);

    apply_settings(15'd0, 16'd10, 16'd20, 16'd30, 16'd40, 16'd50);
    set_idling(38, 38, 1'b0);
    run_random(PHASE_ITEMS);

    // The receiver holds off for a long stretch while requests keep coming.
    apply_settings(15'($urandom_range(4000)), 16'($urandom_range(200)),
                   16'($urandom_range(200)), 16'($urandom_range(200)),
                   16'($urandom_range(200)), 16'($urandom_range(200)));
    set_idling(0, 0, 1'b1);
    run_random(PHASE_ITEMS);

    apply_settings(15'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), 16'($urandom));
    set_idling(38, 38, 1'b0);
    run_random(PHASE_ITEMS);

    in_valid <= 1'b0;
    while (sb.expected_outputs.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (sb.errors == 0 && sb.expected_outputs.size() == 0) begin
      $display("[motor_driver_enable_sequencer_core] OK");
    end else begin
      $display("[motor_driver_enable_sequencer_core] ERROR");
    end
    $finish;
  end

endmodule
